[rtl/i2c_master_transfer_sequencer_top_macros.svh]
// ---------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// Short forms for the clocked, reset-qualified checks used in the top level.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define I2CMTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define I2CMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2cmts_pkg.sv]
// ---------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared codes, result types and helpers for the sequencer modules.
// ---------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int LEN_W                 = 9;
  localparam int DEF_MAX_MESSAGE_BYTES = 256;
  localparam int RES_SLOTS             = 3;
  localparam logic [2:0] DEF_MAX_RETRIES = 3'd2;

  // Event codes carried by a request word.
  localparam logic [2:0] REQ_LOAD      = 3'd0;
  localparam logic [2:0] REQ_START     = 3'd1;
  localparam logic [2:0] REQ_ADDR_ACK  = 3'd2;
  localparam logic [2:0] REQ_TX_EMPTY  = 3'd3;
  localparam logic [2:0] REQ_BYTE_FIN  = 3'd4;
  localparam logic [2:0] REQ_RX_BYTE   = 3'd5;
  localparam logic [2:0] REQ_NACK      = 3'd6;
  localparam logic [2:0] REQ_RX_ERR    = 3'd7;

  // Action codes carried by a result word.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_ADDR  = 3'd2;
  localparam logic [2:0] ACT_SEND  = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;
  localparam logic [2:0] ACT_STORE = 3'd5;
  localparam logic [2:0] ACT_ACK   = 3'd6;
  localparam logic [2:0] ACT_DONE  = 3'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic       ack_on;
    logic       success;
  } res_t;

  typedef struct packed {
    res_t [RES_SLOTS-1:0] res;
    logic [1:0]           cnt;
  } bundle_t;

  typedef struct packed {
    logic busy;
    logic final_take;
  } q_status_t;

  function automatic res_t mk_res(input logic [2:0] act, input logic [7:0] b,
                                  input logic [7:0] idx, input logic ack,
                                  input logic ok);
    res_t r;
    r.action     = act;
    r.out_byte   = b;
    r.byte_index = idx;
    r.ack_on     = ack;
    r.success    = ok;
    return r;
  endfunction

endpackage

[rtl/i2cmts_core.sv]
// ---------------------------------------------------------------------------
// I2C master transfer sequencer core
// Message state and the single-pass decode of one event into its results.
// ---------------------------------------------------------------------------
module i2cmts_core import i2cmts_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_wr_data,
  input  logic             accept,
  input  logic [2:0]       req_type,
  input  logic [6:0]       slave_address,
  input  logic             read_dir,
  input  logic             has_reg_addr,
  input  logic             reg_addr_wide,
  input  logic [15:0]      reg_addr,
  input  logic [LEN_W-1:0] msg_length,
  input  logic [7:0]       data_byte,
  input  logic             bus_in_transmit,
  output bundle_t          bundle
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_WRITE = 3'd3;
  localparam logic [2:0] PH_FLUSH = 3'd4;
  localparam logic [2:0] PH_READ  = 3'd5;

  localparam logic [16:0] MAX_LEN = 17'(MAX_MESSAGE_BYTES);

  logic [2:0]       max_retries_r, max_retries_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [6:0]       target_r, target_nxt;
  logic             is_read_r, is_read_nxt;
  logic             pend_r, pend_nxt;
  logic             wide_r, wide_nxt;
  logic [15:0]      raddr_r, raddr_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [LEN_W-1:0] done_r, done_nxt;
  logic [2:0]       retries_r, retries_nxt;

  logic [LEN_W-1:0] len_lo, len_clamped, done_inc, remain;
  logic [7:0]       addr_wr;

  assign len_lo      = (msg_length == '0) ? LEN_W'(1) : msg_length;
  assign len_clamped = ({8'd0, len_lo} > MAX_LEN) ? MAX_LEN[LEN_W-1:0] : len_lo;
  assign done_inc    = done_r + LEN_W'(1);
  assign remain      = total_r - done_inc;
  assign addr_wr     = {target_r, 1'b0};

  always_comb begin
    logic [1:0] n_v;
    logic       do_store;
    logic       do_finish;
    logic       fin_ok;
    n_v         = 2'd0;
    do_store    = 1'b0;
    do_finish   = 1'b0;
    fin_ok      = 1'b0;
    bundle      = '0;
    max_retries_nxt = cfg_wr_en ? cfg_wr_data : max_retries_r;
    phase_nxt   = phase_r;
    target_nxt  = target_r;
    is_read_nxt = is_read_r;
    pend_nxt    = pend_r;
    wide_nxt    = wide_r;
    raddr_nxt   = raddr_r;
    total_nxt   = total_r;
    done_nxt    = done_r;
    retries_nxt = retries_r;

    unique case (req_type)
      REQ_LOAD: begin
        target_nxt  = slave_address;
        is_read_nxt = read_dir;
        pend_nxt    = has_reg_addr;
        wide_nxt    = reg_addr_wide;
        raddr_nxt   = reg_addr;
        total_nxt   = len_clamped;
        done_nxt    = '0;
        retries_nxt = max_retries_r;
        phase_nxt   = PH_START;
        bundle.res[n_v] = mk_res(ACT_START, 8'd0, 8'd0, 1'b0, 1'b0);
        n_v = n_v + 2'd1;
      end
      REQ_START: begin
        if (phase_r == PH_START) begin
          done_nxt = '0;
          if (!is_read_r || pend_r) begin
            bundle.res[n_v] = mk_res(ACT_ADDR, addr_wr, 8'd0, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
          end else begin
            bundle.res[n_v] = mk_res(ACT_ACK, 8'd0, 8'd0, 1'b1, 1'b0);
            n_v = n_v + 2'd1;
            bundle.res[n_v] = mk_res(ACT_ADDR, {target_r, 1'b1}, 8'd0, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
          end
          phase_nxt = PH_ADDR;
        end
      end
      REQ_ADDR_ACK: begin
        if (phase_r == PH_ADDR) begin
          if (!is_read_r || pend_r) begin
            if (pend_r) begin
              if (wide_r) begin
                bundle.res[n_v] = mk_res(ACT_SEND, raddr_r[15:8], 8'd0, 1'b0, 1'b0);
                n_v = n_v + 2'd1;
              end
              bundle.res[n_v] = mk_res(ACT_SEND, raddr_r[7:0], 8'd0, 1'b0, 1'b0);
              n_v = n_v + 2'd1;
              pend_nxt = 1'b0;
            end
            phase_nxt = is_read_r ? PH_FLUSH : PH_WRITE;
          end else begin
            bundle.res[n_v] = mk_res(ACT_ACK, 8'd0, 8'd0, (total_r != LEN_W'(1)), 1'b0);
            n_v = n_v + 2'd1;
            phase_nxt = PH_READ;
          end
        end
      end
      REQ_TX_EMPTY: begin
        if (phase_r == PH_WRITE && done_r < total_r) begin
          bundle.res[n_v] = mk_res(ACT_SEND, data_byte, done_r[7:0], 1'b0, 1'b0);
          n_v = n_v + 2'd1;
          done_nxt = done_inc;
        end
      end
      REQ_BYTE_FIN: begin
        if (bus_in_transmit) begin
          if (phase_r == PH_FLUSH) begin
            bundle.res[n_v] = mk_res(ACT_START, 8'd0, 8'd0, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
            phase_nxt = PH_START;
          end else if (phase_r == PH_WRITE && done_r >= total_r) begin
            do_finish = 1'b1;
            fin_ok    = 1'b1;
          end
        end else if (phase_r == PH_READ) begin
          do_store = 1'b1;
        end
      end
      REQ_RX_BYTE: begin
        if (phase_r == PH_READ) begin
          do_store = 1'b1;
        end
      end
      REQ_NACK: begin
        if (phase_r != PH_IDLE) begin
          if (retries_r != 3'd0) begin
            retries_nxt = retries_r - 3'd1;
            bundle.res[n_v] = mk_res(ACT_START, 8'd0, 8'd0, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
            phase_nxt = PH_START;
          end else begin
            do_finish = 1'b1;
          end
        end
      end
      REQ_RX_ERR: begin
        if (phase_r != PH_IDLE) begin
          do_finish = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A stored byte completes the read or, one short of the end, arms a NACK
    // for the final byte; otherwise it is only stored.
    if (do_store) begin
      bundle.res[n_v] = mk_res(ACT_STORE, data_byte, done_r[7:0], 1'b0, 1'b0);
      n_v = n_v + 2'd1;
      done_nxt = done_inc;
      if (done_inc >= total_r) begin
        do_finish = 1'b1;
        fin_ok    = 1'b1;
      end else if (remain == LEN_W'(1)) begin
        bundle.res[n_v] = mk_res(ACT_ACK, 8'd0, 8'd0, 1'b0, 1'b0);
        n_v = n_v + 2'd1;
      end
    end

    if (do_finish) begin
      bundle.res[n_v] = mk_res(ACT_STOP, 8'd0, 8'd0, 1'b0, 1'b0);
      n_v = n_v + 2'd1;
      bundle.res[n_v] = mk_res(ACT_DONE, 8'd0, 8'd0, 1'b0, fin_ok);
      n_v = n_v + 2'd1;
      phase_nxt = PH_IDLE;
    end

    // An event with no effect still answers with a single empty result.
    if (n_v == 2'd0) begin
      bundle.res[n_v] = mk_res(ACT_NONE, 8'd0, 8'd0, 1'b0, 1'b0);
      n_v = n_v + 2'd1;
    end
    bundle.cnt = n_v;

    if (!accept) begin
      phase_nxt   = phase_r;
      target_nxt  = target_r;
      is_read_nxt = is_read_r;
      pend_nxt    = pend_r;
      wide_nxt    = wide_r;
      raddr_nxt   = raddr_r;
      total_nxt   = total_r;
      done_nxt    = done_r;
      retries_nxt = retries_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= DEF_MAX_RETRIES;
      phase_r       <= PH_IDLE;
      target_r      <= '0;
      is_read_r     <= 1'b0;
      pend_r        <= 1'b0;
      wide_r        <= 1'b0;
      raddr_r       <= '0;
      total_r       <= '0;
      done_r        <= '0;
      retries_r     <= '0;
    end else begin
      max_retries_r <= max_retries_nxt;
      phase_r       <= phase_nxt;
      target_r      <= target_nxt;
      is_read_r     <= is_read_nxt;
      pend_r        <= pend_nxt;
      wide_r        <= wide_nxt;
      raddr_r       <= raddr_nxt;
      total_r       <= total_nxt;
      done_r        <= done_nxt;
      retries_r     <= retries_nxt;
    end
  end

endmodule

[rtl/i2cmts_outq.sv]
// ---------------------------------------------------------------------------
// I2C master transfer sequencer result register
// Holds the results of one event and hands them out one word per cycle while out_stall is low.
// ---------------------------------------------------------------------------
module i2cmts_outq import i2cmts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  bundle_t    bundle_in,
  input  logic       out_stall,
  output logic       out_valid,
  output res_t       out_res,
  output logic       out_last,
  output q_status_t  status
);

  bundle_t    bundle_r, bundle_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       valid_r, valid_nxt;
  logic       take, is_last;

  assign take      = valid_r && !out_stall;
  assign is_last   = (pos_r == (bundle_r.cnt - 2'd1));
  assign out_valid = valid_r;
  assign out_res   = bundle_r.res[pos_r];
  assign out_last  = is_last;

  assign status.busy       = valid_r;
  assign status.final_take = take && is_last;

  always_comb begin
    bundle_nxt = bundle_r;
    pos_nxt    = pos_r;
    valid_nxt  = valid_r;
    if (load) begin
      bundle_nxt = bundle_in;
      pos_nxt    = 2'd0;
      valid_nxt  = 1'b1;
    end else if (take) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bundle_r <= bundle_nxt;
    if (!rst_n) begin
      pos_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

[rtl/i2c_master_transfer_sequencer_top.sv]
// ---------------------------------------------------------------------------
// I2C master transfer sequencer
// Turns I2C bus events into the actions of one register-access message.
// ---------------------------------------------------------------------------
// Each accepted event word is decoded in the cycle it is accepted: the
// message state updates at that edge and the one to three result words it
// causes are captured in the result register. Result words then leave one
// per cycle on the output channel while out_stall is low, the final one
// flagged by out_last. A new event is accepted while results are pending
// only in the cycle in which the final result of the previous event is
// taken, so with a free output side an event that yields one result is
// taken every cycle, and an event with more results holds the event channel
// until its final result is taken. The output port, which moves one result
// word per cycle, sets the event rate. The retry count register can be
// written at any time but is sampled only when a message is loaded.
module i2c_master_transfer_sequencer_top import i2cmts_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  // Configuration: maximum number of restarts after a NACK.
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_wr_data,
  // Event channel.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_req_type,
  input  logic [6:0]       in_slave_address,
  input  logic             in_read_dir,
  input  logic             in_has_reg_addr,
  input  logic             in_reg_addr_wide,
  input  logic [15:0]      in_reg_addr,
  input  logic [LEN_W-1:0] in_msg_length,
  input  logic [7:0]       in_data_byte,
  input  logic             in_bus_in_transmit,
  // Result channel.
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_action,
  output logic [7:0]       out_byte,
  output logic [7:0]       out_byte_index,
  output logic             out_ack_on,
  output logic             out_success,
  output logic             out_last
);

  `include "i2c_master_transfer_sequencer_top_macros.svh"

  bundle_t   bundle;
  q_status_t q_status;
  res_t      cur_res;
  logic      in_accept;

  // The result register is free once its last word is being taken, so the
  // next event can be decoded in that same cycle without a bubble.
  assign in_stall  = q_status.busy && !q_status.final_take;
  assign in_accept = in_valid && !in_stall;

  i2cmts_core #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .accept          (in_accept),
    .req_type        (in_req_type),
    .slave_address   (in_slave_address),
    .read_dir        (in_read_dir),
    .has_reg_addr    (in_has_reg_addr),
    .reg_addr_wide   (in_reg_addr_wide),
    .reg_addr        (in_reg_addr),
    .msg_length      (in_msg_length),
    .data_byte       (in_data_byte),
    .bus_in_transmit (in_bus_in_transmit),
    .bundle          (bundle)
  );

  i2cmts_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .bundle_in (bundle),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (cur_res),
    .out_last  (out_last),
    .status    (q_status)
  );

  assign out_action     = cur_res.action;
  assign out_byte       = cur_res.out_byte;
  assign out_byte_index = cur_res.byte_index;
  assign out_ack_on     = cur_res.ack_on;
  assign out_success    = cur_res.success;

  // An event is taken only when no earlier result would be overwritten.
  `I2CMTS_ASSERT_SAME(a_no_overrun, in_valid && !in_stall, !out_valid || (!out_stall && out_last), "event accepted over pending results")

  // Every accepted event shows a result in the next cycle.
  `I2CMTS_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid, "accepted event produced no result")

  // A result that is not the final one is always followed by another.
  `I2CMTS_ASSERT_NEXT(a_burst_continues, out_valid && !out_stall && !out_last, out_valid, "result burst cut short")

  // An empty result always stands alone.
  `I2CMTS_ASSERT_SAME(a_none_alone, out_valid && (out_action == ACT_NONE), out_last, "empty result not final")

endmodule
